// File: src/screen_point_to_hex_cell_assert.svh
// Assertion shorthands for the grid cell picker checker.
// Both sample on aclk and are off while aresetn is low.
`ifndef SCREEN_POINT_TO_HEX_CELL_ASSERT_SVH
`define SCREEN_POINT_TO_HEX_CELL_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SPHC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SPHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sphc_pkg.sv
package sphc_pkg;

    // Fraction bits of the world coordinates
    localparam int FRAC_BITS = 16;

    // Centered coordinates in half pixels and their magnitude
    localparam int CTR_W  = 18;
    localparam int CMAG_W = 17;

    // x / sqrt(3): magnitude times round(2^32 / sqrt(3)), then a rounding shift
    localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;
    localparam int SHX  = 33 - FRAC_BITS;
    localparam int PX_W = CMAG_W + 32;

    // Divide by 3 through a reciprocal, exact for dividends below 2^19
    localparam int          RECIP3_SH = 19;
    localparam int          RECIP3_W  = 18;
    localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'((2**RECIP3_SH + 2) / 3);
    localparam int PY_W = CMAG_W + RECIP3_W;

    // Scaled magnitudes before the zoom gain
    localparam int MAG_W = 16 + FRAC_BITS;
    localparam logic [MAG_W-1:0] THIRD_1 = MAG_W'((2**FRAC_BITS + 1) / 3);
    localparam logic [MAG_W-1:0] THIRD_2 = MAG_W'((2 * 2**FRAC_BITS + 1) / 3);

    // Zoom gain product, Q8.24 gain
    localparam int GAIN_SH = 24;
    localparam int GP_W    = MAG_W + 32;

    // World values and the hex working width (Q.(FRAC_BITS+1))
    localparam int WORLD_W = 32;
    localparam int HEX_W   = WORLD_W + 2;
    localparam int INT_W   = HEX_W - FRAC_BITS + 2;
    localparam int ERR_W   = FRAC_BITS + 1;

    localparam logic signed [INT_W-1:0] OUT_MAX = INT_W'(32767);
    localparam logic signed [INT_W-1:0] OUT_MIN = INT_W'(-32768);

    // Register stages from input to output register
    localparam int PIPE_DEPTH = 8;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 2);

    // Grid layouts
    localparam logic LAYOUT_HEX  = 1'b0;
    localparam logic LAYOUT_RECT = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_VIEWPORT_WIDTH  = 3'd0,
        REG_VIEWPORT_HEIGHT = 3'd1,
        REG_OFFSET_X        = 3'd2,
        REG_OFFSET_Y        = 3'd3,
        REG_ZOOM_GAIN       = 3'd4,
        REG_LAYOUT_MODE     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [13:0]                viewport_width;
        logic [13:0]                viewport_height;
        logic signed [WORLD_W-1:0]  offset_x;
        logic signed [WORLD_W-1:0]  offset_y;
        logic [31:0]                zoom_gain;
        logic                       layout_mode;
    } cfg_t;

    // Scaled point: sign and magnitude per axis, before the gain
    typedef struct packed {
        logic             neg_x;
        logic [MAG_W-1:0] mag_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_y;
    } scaled_t;

    // World point, signed Q.FRAC_BITS
    typedef struct packed {
        logic [WORLD_W-1:0] wx;
        logic [WORLD_W-1:0] wy;
    } world_t;

endpackage

// File: src/sphc_scale.sv
module sphc_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sphc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          screen_x,
    input  logic [15:0]          screen_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sphc_pkg::scaled_t    out_data
);

    logic [2:0] valid_reg;
    logic       adv0, adv1, adv2;

    // Stage 0: centered magnitudes
    logic [sphc_pkg::CTR_W-1:0]  mx2, my2;
    logic [sphc_pkg::CMAG_W-1:0] x_mag0_reg, y_mag0_reg;
    logic                        x_neg0_reg, y_neg0_reg;

    // Stage 1: products
    logic [sphc_pkg::PX_W-1:0]   px1_reg;
    logic [sphc_pkg::PY_W-1:0]   py1_reg;
    logic [sphc_pkg::CMAG_W-1:0] y_mag1_reg;
    logic                        x_neg1_reg, y_neg1_reg;

    // Stage 2: scaled values
    logic [sphc_pkg::PX_W:0]     px_rnd;
    logic [sphc_pkg::CMAG_W-1:0] quo, rem_full;
    logic [1:0]                  rem;
    logic [sphc_pkg::MAG_W-1:0]  third;
    sphc_pkg::scaled_t           scaled_next;
    sphc_pkg::scaled_t           out_reg;

    // Advance a stage when it is empty or its successor advances
    assign adv2     = !valid_reg[2] || out_ready;
    assign adv1     = !valid_reg[1] || adv2;
    assign adv0     = !valid_reg[0] || adv1;
    assign in_ready = adv0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv0) valid_reg[0] <= in_valid;
            if (adv1) valid_reg[1] <= valid_reg[0];
            if (adv2) valid_reg[2] <= valid_reg[1];
        end
    end

    // Center on the viewport in half pixels, flip y
    always_comb begin
        mx2 = {{(sphc_pkg::CTR_W-17){screen_x[15]}}, screen_x, 1'b0}
              - sphc_pkg::CTR_W'(cfg.viewport_width);
        my2 = sphc_pkg::CTR_W'(cfg.viewport_height)
              - {{(sphc_pkg::CTR_W-17){screen_y[15]}}, screen_y, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            x_neg0_reg <= mx2[sphc_pkg::CTR_W-1];
            x_mag0_reg <= mx2[sphc_pkg::CTR_W-1] ? sphc_pkg::CMAG_W'(-mx2)
                                                  : sphc_pkg::CMAG_W'(mx2);
            // y result carries the opposite sign of the centered row
            y_neg0_reg <= !my2[sphc_pkg::CTR_W-1] && (my2 != '0);
            y_mag0_reg <= my2[sphc_pkg::CTR_W-1] ? sphc_pkg::CMAG_W'(-my2)
                                                  : sphc_pkg::CMAG_W'(my2);
        end
    end

    // Multiply x by 1/sqrt(3), y by the reciprocal of 3
    always_ff @(posedge aclk) begin
        if (adv1) begin
            px1_reg    <= sphc_pkg::PX_W'(x_mag0_reg) * sphc_pkg::PX_W'(sphc_pkg::INV_SQRT3_Q32);
            py1_reg    <= sphc_pkg::PY_W'(y_mag0_reg) * sphc_pkg::PY_W'(sphc_pkg::RECIP3);
            y_mag1_reg <= y_mag0_reg;
            x_neg1_reg <= x_neg0_reg;
            y_neg1_reg <= y_neg0_reg;
        end
    end

    // Round x; rebuild y*2^F/3 from quotient and remainder, rounded to nearest
    always_comb begin
        px_rnd   = {1'b0, px1_reg}
                   + ((sphc_pkg::PX_W+1)'(1) << (sphc_pkg::SHX - 1));
        quo      = sphc_pkg::CMAG_W'(py1_reg >> sphc_pkg::RECIP3_SH);
        rem_full = y_mag1_reg - (quo + (quo << 1));
        rem      = rem_full[1:0];
        case (rem)
            2'd0:    third = '0;
            2'd1:    third = sphc_pkg::THIRD_1;
            default: third = sphc_pkg::THIRD_2;
        endcase
        scaled_next.neg_x = x_neg1_reg;
        scaled_next.mag_x = sphc_pkg::MAG_W'(px_rnd >> sphc_pkg::SHX);
        scaled_next.neg_y = y_neg1_reg;
        scaled_next.mag_y = (sphc_pkg::MAG_W'(quo) << sphc_pkg::FRAC_BITS) + third;
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            out_reg <= scaled_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule

// File: src/sphc_gain.sv
module sphc_gain (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sphc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sphc_pkg::scaled_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sphc_pkg::world_t     out_data
);

    logic [2:0] valid_reg;
    logic       adv0, adv1, adv2;

    logic [sphc_pkg::GP_W-1:0]    prod0_reg [2];
    logic                         neg0_reg  [2];
    logic [sphc_pkg::WORLD_W-1:0] gain1_reg [2];
    logic [sphc_pkg::WORLD_W-1:0] gain_next [2];
    logic [sphc_pkg::WORLD_W-1:0] world_next [2];
    logic [sphc_pkg::WORLD_W-1:0] offset    [2];
    logic [sphc_pkg::MAG_W-1:0]   mag_in    [2];
    logic                         neg_in    [2];
    sphc_pkg::world_t             out_reg;

    // Round product / 2^24 half away from zero, sign it, saturate to 32 bits
    function automatic logic [sphc_pkg::WORLD_W-1:0] gain_round(
        input logic [sphc_pkg::GP_W-1:0] prod,
        input logic                      neg
    );
        logic [sphc_pkg::GP_W:0]                 sum;
        logic [sphc_pkg::GP_W-sphc_pkg::GAIN_SH:0] rs;
        logic [sphc_pkg::WORLD_W-1:0]            r32;
        sum = {1'b0, prod} + ((sphc_pkg::GP_W+1)'(1) << (sphc_pkg::GAIN_SH - 1));
        rs  = sum[sphc_pkg::GP_W:sphc_pkg::GAIN_SH];
        if (rs > (($bits(rs))'(1) << (sphc_pkg::WORLD_W - 1))) begin
            r32 = {1'b1, {(sphc_pkg::WORLD_W-1){1'b0}}};
        end else begin
            r32 = rs[sphc_pkg::WORLD_W-1:0];
        end
        if (neg) begin
            gain_round = -r32;
        end else if (r32[sphc_pkg::WORLD_W-1]) begin
            gain_round = {1'b0, {(sphc_pkg::WORLD_W-1){1'b1}}};
        end else begin
            gain_round = r32;
        end
    endfunction

    // Signed add with saturation to 32 bits
    function automatic logic [sphc_pkg::WORLD_W-1:0] add_sat(
        input logic [sphc_pkg::WORLD_W-1:0] a,
        input logic [sphc_pkg::WORLD_W-1:0] b
    );
        logic [sphc_pkg::WORLD_W:0] sum;
        sum = {a[sphc_pkg::WORLD_W-1], a} + {b[sphc_pkg::WORLD_W-1], b};
        if (sum[sphc_pkg::WORLD_W] != sum[sphc_pkg::WORLD_W-1]) begin
            add_sat = sum[sphc_pkg::WORLD_W] ? {1'b1, {(sphc_pkg::WORLD_W-1){1'b0}}}
                                             : {1'b0, {(sphc_pkg::WORLD_W-1){1'b1}}};
        end else begin
            add_sat = sum[sphc_pkg::WORLD_W-1:0];
        end
    endfunction

    assign adv2     = !valid_reg[2] || out_ready;
    assign adv1     = !valid_reg[1] || adv2;
    assign adv0     = !valid_reg[0] || adv1;
    assign in_ready = adv0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv0) valid_reg[0] <= in_valid;
            if (adv1) valid_reg[1] <= valid_reg[0];
            if (adv2) valid_reg[2] <= valid_reg[1];
        end
    end

    // Spread the two axes into lanes
    always_comb begin
        mag_in[0] = in_data.mag_x;
        mag_in[1] = in_data.mag_y;
        neg_in[0] = in_data.neg_x;
        neg_in[1] = in_data.neg_y;
        offset[0] = cfg.offset_x;
        offset[1] = cfg.offset_y;
        for (int i = 0; i < 2; i++) begin
            gain_next[i]  = gain_round(prod0_reg[i], neg0_reg[i]);
            world_next[i] = add_sat(gain1_reg[i], offset[i]);
        end
    end

    // Multiply by the zoom gain
    always_ff @(posedge aclk) begin
        if (adv0) begin
            for (int i = 0; i < 2; i++) begin
                prod0_reg[i] <= sphc_pkg::GP_W'(mag_in[i]) * sphc_pkg::GP_W'(cfg.zoom_gain);
                neg0_reg[i]  <= neg_in[i];
            end
        end
    end

    // Round and saturate the gained value
    always_ff @(posedge aclk) begin
        if (adv1) begin
            for (int i = 0; i < 2; i++) begin
                gain1_reg[i] <= gain_next[i];
            end
        end
    end

    // Add the translation
    always_ff @(posedge aclk) begin
        if (adv2) begin
            out_reg.wx <= world_next[0];
            out_reg.wy <= world_next[1];
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule

// File: src/sphc_round.sv
module sphc_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sphc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sphc_pkg::world_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          cell_col,
    output logic [15:0]          cell_row
);

    typedef struct packed {
        logic signed [sphc_pkg::INT_W-1:0] val;
        logic [sphc_pkg::ERR_W-1:0]        err;
    } rnd_t;

    logic [1:0] valid_reg;
    logic       adv0, adv1;

    logic [sphc_pkg::HEX_W-1:0] wx_e, wy_e, wx2, r_v, q_v, s_v;
    rnd_t q_rnd_reg, r_rnd_reg, s_rnd_reg;
    logic signed [sphc_pkg::INT_W-1:0] col_rect_reg, row_rect_reg;
    logic signed [sphc_pkg::INT_W-1:0] qf, rf, col_sel, row_sel;
    logic [15:0] col_reg, row_reg;

    // Round Q.(F+1) to integer half away from zero, keep the error
    function automatic rnd_t round_hex(input logic [sphc_pkg::HEX_W-1:0] v);
        logic                                        neg;
        logic [sphc_pkg::HEX_W-1:0]                  m;
        logic [sphc_pkg::HEX_W:0]                    t;
        logic [sphc_pkg::HEX_W-sphc_pkg::FRAC_BITS-1:0] im;
        logic [sphc_pkg::ERR_W-1:0]                  fr;
        logic [sphc_pkg::INT_W-1:0]                  ext;
        rnd_t                                        res;
        neg = v[sphc_pkg::HEX_W-1];
        m   = neg ? -v : v;
        t   = {1'b0, m} + ((sphc_pkg::HEX_W+1)'(1) << sphc_pkg::FRAC_BITS);
        im  = t[sphc_pkg::HEX_W:sphc_pkg::FRAC_BITS+1];
        fr  = m[sphc_pkg::FRAC_BITS:0];
        ext = sphc_pkg::INT_W'(im);
        res.val = neg ? -ext : ext;
        res.err = fr[sphc_pkg::FRAC_BITS] ? (~fr + 1'b1) : fr;
        return res;
    endfunction

    // Round Q.F to integer half away from zero
    function automatic logic [sphc_pkg::INT_W-1:0] round_rect(
        input logic [sphc_pkg::HEX_W-1:0] v
    );
        logic                                          neg;
        logic [sphc_pkg::HEX_W-1:0]                    m;
        logic [sphc_pkg::HEX_W:0]                      t;
        logic [sphc_pkg::HEX_W-sphc_pkg::FRAC_BITS:0]  im;
        logic [sphc_pkg::INT_W-1:0]                    ext;
        neg = v[sphc_pkg::HEX_W-1];
        m   = neg ? -v : v;
        t   = {1'b0, m} + ((sphc_pkg::HEX_W+1)'(1) << (sphc_pkg::FRAC_BITS - 1));
        im  = t[sphc_pkg::HEX_W:sphc_pkg::FRAC_BITS];
        ext = sphc_pkg::INT_W'(im);
        return neg ? -ext : ext;
    endfunction

    // Clamp to the 16-bit signed output range
    function automatic logic [15:0] sat16(input logic signed [sphc_pkg::INT_W-1:0] v);
        if (v > sphc_pkg::OUT_MAX) begin
            return 16'h7FFF;
        end else if (v < sphc_pkg::OUT_MIN) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    assign adv1     = !valid_reg[1] || out_ready;
    assign adv0     = !valid_reg[0] || adv1;
    assign in_ready = adv0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv0) valid_reg[0] <= in_valid;
            if (adv1) valid_reg[1] <= valid_reg[0];
        end
    end

    // Form axial q, r, s in Q.(F+1) so that q = x - y/2 stays exact
    always_comb begin
        wx_e = {{(sphc_pkg::HEX_W-sphc_pkg::WORLD_W){in_data.wx[sphc_pkg::WORLD_W-1]}},
                in_data.wx};
        wy_e = {{(sphc_pkg::HEX_W-sphc_pkg::WORLD_W){in_data.wy[sphc_pkg::WORLD_W-1]}},
                in_data.wy};
        wx2  = wx_e << 1;
        r_v  = wy_e << 1;
        q_v  = wx2 - wy_e;
        s_v  = -q_v - r_v;
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            q_rnd_reg    <= round_hex(q_v);
            r_rnd_reg    <= round_hex(r_v);
            s_rnd_reg    <= round_hex(s_v);
            col_rect_reg <= round_rect(wx_e);
            row_rect_reg <= round_rect(wy_e);
        end
    end

    // Rebuild the component with the largest error, convert to odd-r offset; rect layout takes the rounded x, y
    always_comb begin
        qf = q_rnd_reg.val;
        rf = r_rnd_reg.val;
        if (q_rnd_reg.err > r_rnd_reg.err && q_rnd_reg.err > s_rnd_reg.err) begin
            qf = -r_rnd_reg.val - s_rnd_reg.val;
        end else if (r_rnd_reg.err > s_rnd_reg.err) begin
            rf = -q_rnd_reg.val - s_rnd_reg.val;
        end
        if (cfg.layout_mode == sphc_pkg::LAYOUT_RECT) begin
            col_sel = col_rect_reg;
            row_sel = row_rect_reg;
        end else begin
            col_sel = qf + (rf >>> 1);
            row_sel = rf;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            col_reg <= sat16(col_sel);
            row_reg <= sat16(row_sel);
        end
    end

    assign out_valid = valid_reg[1];
    assign cell_col  = col_reg;
    assign cell_row  = row_reg;

endmodule

// File: src/screen_point_to_hex_cell.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: screen_x, screen_y
// m_        out        m_tvalid/m_tready  m_tdata: cell_col, cell_row
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One point per cycle unless m_tready stalls the output; each point goes from its
// s_ transfer to m_tdata through the eight register stages (centering, scale multiply,
// scale rounding, gain multiply, gain rounding, translation, cube rounding, offset
// conversion), the first of which loads at the transfer edge itself.
// aresetn is synchronous: it empties the pipeline and loads register defaults.
// A stage holds only while the stage after it is full and stalled, so bubbles
// collapse and s_tready stays high whenever m_tvalid is low.
module screen_point_to_hex_cell (
    input  logic        aclk,
    input  logic        aresetn,
    // Input points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] screen_x, [31:16] screen_y
    // Result cells
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [15:0] cell_col, [31:16] cell_row
    // Register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    sphc_pkg::cfg_t    cfg_reg;
    sphc_pkg::scaled_t scaled;
    sphc_pkg::world_t  world;
    logic              scaled_valid, scaled_ready;
    logic              world_valid, world_ready;
    logic [15:0]       cell_col, cell_row;

    assign cfg_ready = 1'b1;

    // Load a register on each write transfer; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.viewport_width  <= 14'd1024;
            cfg_reg.viewport_height <= 14'd768;
            cfg_reg.offset_x        <= '0;
            cfg_reg.offset_y        <= '0;
            cfg_reg.zoom_gain       <= 32'd16777216;
            cfg_reg.layout_mode     <= sphc_pkg::LAYOUT_HEX;
        end else if (cfg_valid && cfg_ready) begin
            case (sphc_pkg::reg_index_t'(cfg_index))
                sphc_pkg::REG_VIEWPORT_WIDTH:  cfg_reg.viewport_width  <= cfg_data[13:0];
                sphc_pkg::REG_VIEWPORT_HEIGHT: cfg_reg.viewport_height <= cfg_data[13:0];
                sphc_pkg::REG_OFFSET_X:        cfg_reg.offset_x        <= cfg_data;
                sphc_pkg::REG_OFFSET_Y:        cfg_reg.offset_y        <= cfg_data;
                sphc_pkg::REG_ZOOM_GAIN:       cfg_reg.zoom_gain       <= cfg_data;
                sphc_pkg::REG_LAYOUT_MODE:     cfg_reg.layout_mode     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Center and scale to the unit grid
    sphc_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .screen_x  (s_tdata[15:0]),
        .screen_y  (s_tdata[31:16]),
        .out_valid (scaled_valid),
        .out_ready (scaled_ready),
        .out_data  (scaled)
    );

    // Apply zoom gain and translation
    sphc_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (scaled_valid),
        .in_ready  (scaled_ready),
        .in_data   (scaled),
        .out_valid (world_valid),
        .out_ready (world_ready),
        .out_data  (world)
    );

    // Round to a cell
    sphc_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (world_valid),
        .in_ready  (world_ready),
        .in_data   (world),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cell_col  (cell_col),
        .cell_row  (cell_row)
    );

    assign m_tdata = {cell_row, cell_col};

endmodule

// File: src/sphc_checker.sv
`include "screen_point_to_hex_cell_assert.svh"

module sphc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [sphc_pkg::CNT_W-1:0] count_reg, count_next;

    // Track points inside the block
    always_comb begin
        count_next = count_reg;
        if (s_tvalid && s_tready) begin
            count_next = count_next + 1'b1;
        end
        if (m_tvalid && m_tready) begin
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    `SPHC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `SPHC_ASSERT_IMPLIES(a_no_phantom, m_tvalid, count_reg != '0, "result without a pending point")
    `SPHC_ASSERT_IMPLIES(a_depth, s_tvalid || m_tvalid, count_reg <= sphc_pkg::CNT_W'(sphc_pkg::PIPE_DEPTH), "more points held than stages")
    `SPHC_ASSERT_IMPLIES(a_drain_ready, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind screen_point_to_hex_cell sphc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef longint unsigned u64_t;

    // Spare register indexes: writes to them must be dropped
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam int     XSHIFT      = 33 - sphc_pkg::FRAC_BITS;
    localparam longint WORLD_MAX   = 64'sd2147483647;
    localparam longint WORLD_MIN   = -64'sd2147483648;
    localparam longint CELL_MAX    = 32767;
    localparam longint CELL_MIN    = -32768;
    localparam int     STALL_LIMIT = 2000;
    localparam int     PRINT_LIMIT = 40;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] col;
        logic signed [15:0] row;
    } cell_expect_t;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] value;
    } reg_write_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // [15:0] screen_x, [31:16] screen_y
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [15:0] cell_col, [31:16] cell_row
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Register image kept by the testbench, loaded with the reset values
    longint vp_width    = 1024;
    longint vp_height   = 768;
    longint world_off_x = 0;
    longint world_off_y = 0;
    u64_t   zoom_q24    = 64'd16777216;
    logic   grid_layout = sphc_pkg::LAYOUT_HEX;

    cell_expect_t pending_cells[$];
    reg_write_t   staged_writes[$];

    bit idle_on = 1'b1;
    int sink_hold = 0;
    int points_sent = 0;
    int cells_checked = 0;
    int reg_writes_done = 0;
    int fail_count = 0;

    screen_point_to_hex_cell u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Cell prediction
    // ---------------------------------------------------------------
    function automatic u64_t magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Multiply by the Q8.24 gain, round half away from zero, saturate to 32 bits
    function automatic longint scale_by_gain(input longint v);
        u64_t   m;
        u64_t   hi;
        u64_t   lo;
        u64_t   r;
        longint res;
        m  = magnitude(v);
        hi = m >> 32;
        lo = m & 64'hFFFF_FFFF;
        if (hi > 64'h3_FFFF) begin
            r = 64'h8000_0000;
        end else begin
            r = ((hi * zoom_q24) << 8) + ((lo * zoom_q24 + (64'd1 << 23)) >> 24);
        end
        if (r > 64'h8000_0000) begin
            r = 64'h8000_0000;
        end
        res = (v < 0) ? -longint'(r) : longint'(r);
        return clamp(res, WORLD_MIN, WORLD_MAX);
    endfunction

    // Round a value with fb fraction bits to an integer, half away from zero
    function automatic longint round_half_away(input longint w, input int fb,
                                               output u64_t err);
        u64_t m;
        u64_t i;
        u64_t b;
        m   = magnitude(w);
        i   = (m + (64'd1 << (fb - 1))) >> fb;
        b   = i << fb;
        err = (b > m) ? b - m : m - b;
        return (w < 0) ? -longint'(i) : longint'(i);
    endfunction

    function automatic cell_expect_t locate_cell(input logic signed [15:0] px,
                                                 input logic signed [15:0] py);
        cell_expect_t e;
        longint mx2, my2, vx, vy, wx, wy;
        longint q, r, s, qi, ri, si, col, row;
        u64_t   t, eq, er, es;
        // Center on the viewport in half pixels, y grows upward
        mx2 = 2 * longint'(px) - vp_width;
        my2 = vp_height - 2 * longint'(py);
        // x / sqrt(3)
        t  = magnitude(mx2) * u64_t'(sphc_pkg::INV_SQRT3_Q32);
        t  = (t + (64'd1 << (XSHIFT - 1))) >> XSHIFT;
        vx = (mx2 < 0) ? -longint'(t) : longint'(t);
        // y / -1.5
        t  = magnitude(my2) << sphc_pkg::FRAC_BITS;
        t  = (t + 64'd1) / 64'd3;
        vy = (my2 > 0) ? -longint'(t) : longint'(t);
        // Zoom and translate into world space
        wx = clamp(scale_by_gain(vx) + world_off_x, WORLD_MIN, WORLD_MAX);
        wy = clamp(scale_by_gain(vy) + world_off_y, WORLD_MIN, WORLD_MAX);
        if (grid_layout == sphc_pkg::LAYOUT_HEX) begin
            // Cube coordinates with one extra fraction bit so q is exact
            r  = 2 * wy;
            q  = 2 * wx - wy;
            s  = -q - r;
            qi = round_half_away(q, sphc_pkg::FRAC_BITS + 1, eq);
            ri = round_half_away(r, sphc_pkg::FRAC_BITS + 1, er);
            si = round_half_away(s, sphc_pkg::FRAC_BITS + 1, es);
            // Rebuild the component that is farthest off
            if (eq > er && eq > es) begin
                qi = -ri - si;
            end else if (er > es) begin
                ri = -qi - si;
            end
            // Odd-r offset: shift the column by floor(row / 2)
            col = qi + (ri >>> 1);
            row = ri;
        end else begin
            col = round_half_away(wx, sphc_pkg::FRAC_BITS, eq);
            row = round_half_away(wy, sphc_pkg::FRAC_BITS, er);
        end
        e.px  = px;
        e.py  = py;
        e.col = 16'(clamp(col, CELL_MIN, CELL_MAX));
        e.row = 16'(clamp(row, CELL_MIN, CELL_MAX));
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Shared helpers
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("%0t ERROR %s", $realtime, msg);
        end
    endtask

    task automatic stage_write(input logic [2:0] idx, input logic [31:0] value);
        reg_write_t w;
        w.idx   = idx;
        w.value = value;
        staged_writes.push_back(w);
    endtask

    // Drive all staged register writes back to back; call only while idle
    task automatic commit_registers();
        reg_write_t w;
        while (staged_writes.size() != 0) begin
            w = staged_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.value;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            reg_writes_done++;
            case (w.idx)
                sphc_pkg::REG_VIEWPORT_WIDTH:  vp_width    = w.value[13:0];
                sphc_pkg::REG_VIEWPORT_HEIGHT: vp_height   = w.value[13:0];
                sphc_pkg::REG_OFFSET_X:        world_off_x = longint'($signed(w.value));
                sphc_pkg::REG_OFFSET_Y:        world_off_y = longint'($signed(w.value));
                sphc_pkg::REG_ZOOM_GAIN:       zoom_q24    = w.value;
                sphc_pkg::REG_LAYOUT_MODE:     grid_layout = w.value[0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Send one point; tvalid stays high so the next call can follow at once
    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_cells.push_back(locate_cell(px, py));
        points_sent++;
    endtask

    task automatic send_random_point();
        int px;
        int py;
        if ($urandom_range(0, 9) < 3) begin
            px = $urandom_range(0, 65535) - 32768;
            py = $urandom_range(0, 65535) - 32768;
        end else begin
            px = int'($urandom_range(0, 32'(vp_width) + 400)) - 200;
            py = int'($urandom_range(0, 32'(vp_height) + 400)) - 200;
        end
        send_point(16'(px), 16'(py));
    endtask

    // Stop sending and hold until every predicted cell has come back
    task automatic wait_for_all_cells();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (sphc_pkg::PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Result side: random back pressure and checking
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin : check_cells
        cell_expect_t want;
        logic signed [15:0] got_col;
        logic signed [15:0] got_row;
        if (aresetn && m_tvalid && m_tready) begin
            got_col = m_tdata[15:0];
            got_row = m_tdata[31:16];
            if (pending_cells.size() == 0) begin
                report_failure($sformatf("cell (%0d,%0d) with no point pending",
                                         got_col, got_row));
            end else begin
                want = pending_cells.pop_front();
                cells_checked++;
                if (got_col !== want.col) begin
                    report_failure($sformatf("point (%0d,%0d) cell_col %0d, expected %0d",
                                             want.px, want.py, got_col, want.col));
                end
                if (got_row !== want.row) begin
                    report_failure($sformatf("point (%0d,%0d) cell_row %0d, expected %0d",
                                             want.px, want.py, got_row, want.row));
                end
            end
        end
    end

    // End the run if nothing moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no transfer for %0d cycles, %0d cells outstanding",
                 STALL_LIMIT, pending_cells.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Points at the corners of the input range, the origin and the viewport center, with reset register values
    task automatic test_reset_defaults();
        send_point(16'sd0, 16'sd0);
        send_point(16'sd512, 16'sd384);
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd32767, -16'sd32768);
        send_point(-16'sd32768, 16'sd32767);
        wait_for_all_cells();
    endtask

    // Spare indexes are dropped, register data is masked, viewport extremes
    task automatic test_register_extremes();
        stage_write(REG_SPARE_6, 32'hFFFF_FFFF);
        stage_write(REG_SPARE_7, 32'hFFFF_FFFF);
        commit_registers();
        send_point(16'sd512, 16'sd384);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_LAYOUT_MODE, 32'hFFFF_FFFF);
        stage_write(sphc_pkg::REG_VIEWPORT_WIDTH, 32'hFFFF_FFFF);
        stage_write(sphc_pkg::REG_VIEWPORT_HEIGHT, 32'hFFFF_C000);
        commit_registers();
        send_point(16'sd0, 16'sd0);
        send_point(16'sd16383, -16'sd1);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_VIEWPORT_WIDTH, 32'h0000_0000);
        stage_write(sphc_pkg::REG_VIEWPORT_HEIGHT, 32'h0000_3FFF);
        commit_registers();
        send_point(16'sd0, 16'sd16383);
        wait_for_all_cells();
    endtask

    // Zero gain leaves the translation alone: exact halves and saturated offsets
    task automatic test_zero_gain_and_ties();
        stage_write(sphc_pkg::REG_ZOOM_GAIN, 32'h0000_0000);
        stage_write(sphc_pkg::REG_OFFSET_X, 32'h0000_8000);
        stage_write(sphc_pkg::REG_OFFSET_Y, 32'hFFFF_8000);
        commit_registers();
        send_point(16'sd100, -16'sd100);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_OFFSET_X, 32'h7FFF_FFFF);
        stage_write(sphc_pkg::REG_OFFSET_Y, 32'h8000_0000);
        commit_registers();
        send_point(16'sd0, 16'sd0);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_LAYOUT_MODE, 32'hFFFF_FFFE);
        commit_registers();
        send_point(16'sd0, 16'sd0);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_OFFSET_X, 32'h0000_0000);
        stage_write(sphc_pkg::REG_OFFSET_Y, 32'h0000_8000);
        commit_registers();
        send_point(16'sd7, 16'sd7);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_OFFSET_X, 32'h0000_4000);
        stage_write(sphc_pkg::REG_OFFSET_Y, 32'hFFFF_8000);
        commit_registers();
        send_point(-16'sd7, 16'sd7);
        wait_for_all_cells();
    endtask

    // Largest and smallest nonzero gain, both layouts, outputs driven into saturation
    task automatic test_gain_extremes();
        stage_write(sphc_pkg::REG_OFFSET_X, 32'h0000_0000);
        stage_write(sphc_pkg::REG_OFFSET_Y, 32'h0000_0000);
        stage_write(sphc_pkg::REG_VIEWPORT_WIDTH, 32'd1024);
        stage_write(sphc_pkg::REG_VIEWPORT_HEIGHT, 32'd768);
        stage_write(sphc_pkg::REG_ZOOM_GAIN, 32'hFFFF_FFFF);
        commit_registers();
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd513, 16'sd383);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_LAYOUT_MODE, 32'd1);
        commit_registers();
        send_point(-16'sd32768, 16'sd32767);
        wait_for_all_cells();
        stage_write(sphc_pkg::REG_ZOOM_GAIN, 32'd1);
        commit_registers();
        send_point(16'sd32767, -16'sd32768);
        wait_for_all_cells();
    endtask

    // Back to back points with the result side always ready
    task automatic test_full_rate();
        int n;
        idle_on = 1'b0;
        stage_write(sphc_pkg::REG_ZOOM_GAIN, 32'd16777216);
        stage_write(sphc_pkg::REG_LAYOUT_MODE, 32'd0);
        commit_registers();
        for (n = 0; n < 100; n++) begin
            send_random_point();
        end
        wait_for_all_cells();
        idle_on = 1'b1;
    endtask

    task automatic stage_random_config(input bit rect);
        int          sel;
        logic [31:0] value;
        // Viewport: mostly random, sometimes an extreme or junk upper bits
        sel   = $urandom_range(0, 9);
        value = $urandom_range(0, 16383);
        if (sel == 0) value = 32'd0;
        if (sel == 1) value = 32'h3FFF;
        if (sel == 2) value = value | ($urandom() & 32'hFFFF_C000);
        stage_write(sphc_pkg::REG_VIEWPORT_WIDTH, value);
        sel   = $urandom_range(0, 9);
        value = $urandom_range(0, 16383);
        if (sel == 0) value = 32'd0;
        if (sel == 1) value = 32'h3FFF;
        if (sel == 2) value = value | ($urandom() & 32'hFFFF_C000);
        stage_write(sphc_pkg::REG_VIEWPORT_HEIGHT, value);
        // Gain: mostly near unity so cells stay in range
        sel = $urandom_range(0, 9);
        if (sel < 6) value = $urandom_range(32'h0040_0000, 32'h0400_0000);
        else if (sel == 6) value = $urandom();
        else if (sel == 7) value = $urandom_range(1, 255);
        else if (sel == 8) value = 32'd16777216;
        else value = 32'd0;
        stage_write(sphc_pkg::REG_ZOOM_GAIN, value);
        // Offsets: a few hundred cells either way, sometimes anything
        sel = $urandom_range(0, 9);
        if (sel < 7) value = 32'($urandom_range(0, 400 << 16)) - 32'(200 << 16);
        else if (sel < 9) value = $urandom();
        else value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        stage_write(sphc_pkg::REG_OFFSET_X, value);
        sel = $urandom_range(0, 9);
        if (sel < 7) value = 32'($urandom_range(0, 400 << 16)) - 32'(200 << 16);
        else if (sel < 9) value = $urandom();
        else value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        stage_write(sphc_pkg::REG_OFFSET_Y, value);
        stage_write(sphc_pkg::REG_LAYOUT_MODE, rect ? 32'd1 : 32'd0);
    endtask

    // Random register settings per phase, random points, random stalls
    task automatic test_random_sweep();
        int phase;
        int n;
        for (phase = 0; phase < 11; phase++) begin
            idle_on = (phase % 4) != 3;
            stage_random_config(phase[0]);
            commit_registers();
            for (n = 0; n < 150; n++) begin
                send_random_point();
                // Let the pipeline run dry in the middle of some phases
                if (n == 75 && (phase % 3) == 0) wait_for_all_cells();
            end
            wait_for_all_cells();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_zero_gain_and_ties();
        test_gain_extremes();
        test_full_rate();
        test_random_sweep();
        wait_for_all_cells();

        $display("Sent %0d points, checked %0d cells, made %0d register writes",
                 points_sent, cells_checked, reg_writes_done);
        $display("Hex and rect layouts, zero to full gain, saturated offsets, stalls both sides");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
